[src/brrt_pkg.sv]
// shared constants and types of the beacon reception ratio table
package brrt_pkg;

    localparam int NODE_COUNT_DEF = 32;
    localparam int NODE_W         = 5;
    localparam int CNT_W          = 16;
    localparam int SEQ_W          = 16;
    localparam int STR_W          = 16;
    localparam int SCALE_W        = 14;
    localparam int PROD_W         = CNT_W + SCALE_W;

    localparam logic [SCALE_W-1:0] RATIO_SCALE = SCALE_W'(10000);
    localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
    localparam logic [STR_W-1:0]   STR_MAX     = '1;

    localparam logic MODE_BEACON = 1'b0;
    localparam logic MODE_REPORT = 1'b1;
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_BWR  = 5'b00010,
        S_RD   = 5'b00100,
        S_MUL  = 5'b01000,
        S_DIV  = 5'b10000
    } t_state;

endpackage

[src/brrt_ram.sv]
// generic single-port-write, registered-read ram
module brrt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/brrt_div.sv]
// bit-serial restoring divider with saturation to the strength range
module brrt_div import brrt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [SEQ_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [STR_W-1:0]  o_quotient
);

    localparam int STEP_W = $clog2(PROD_W);

    logic              r_run;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [PROD_W-1:0] r_dvd;
    logic [SEQ_W-1:0]  r_rem;
    logic [SEQ_W-1:0]  r_dsr;
    logic              r_zero;
    logic [SEQ_W:0]    w_sh;
    logic              w_ge;
    logic [SEQ_W:0]    w_diff;

    assign w_sh   = {r_rem, r_dvd[PROD_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_dsr});
    assign w_diff = w_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= STEP_W'(PROD_W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_dividend;
            r_rem  <= '0;
            r_dsr  <= i_divisor;
            r_zero <= (i_divisor == '0);
        end else if (r_run) begin
            r_dvd <= {r_dvd[PROD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[SEQ_W-1:0] : w_sh[SEQ_W-1:0];
        end
    end

    assign o_done = r_done;

    always_comb begin
        if (r_zero) begin
            o_quotient = '0;
        end else if (r_dvd[PROD_W-1:STR_W] != '0) begin
            o_quotient = STR_MAX;
        end else begin
            o_quotient = r_dvd[STR_W-1:0];
        end
    end

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_run) && !r_run)
        else $error("divider done without a finished run");

endmodule

[src/beacon_reception_ratio_table.sv]
// top level of the beacon reception ratio table
//
// Command channel: a transaction is taken at a rising edge where start is
// high and busy is low. i_mode selects a beacon (i_node_id, i_seq) or a
// report. One configuration register, the report floor for the highest node
// id, must be written via i_cfg_we / i_cfg_wdata only while idle, and
// the block does not enforce this. A beacon keeps busy high for one cycle:
// its counter ram entry is read and written back incremented and saturated.
// A report shows its header on the result ports in the cycle after it is
// taken, then one record per node 1..H. Each record goes through one ram
// read, one multiply by 10000, a 30-step bit-serial divide by the highest
// sequence number and a register for the result.
// Every result is valid for exactly one cycle on o_valid; the receiver
// cannot stall, and o_last marks the final result of a report.
// Reset clears the valid bits of the counter ram at once, so every counter
// reads as zero right after reset, along with the highest sequence, the
// highest node and the register.
module beacon_reception_ratio_table import brrt_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic [NODE_W-1:0]  i_node_id,
    input  logic [SEQ_W-1:0]   i_seq,
    input  logic               i_cfg_we,
    input  logic [NODE_W-1:0]  i_cfg_wdata,
    output logic               o_valid,
    output logic               o_kind,
    output logic [NODE_W-1:0]  o_node_id_res,
    output logic [STR_W-1:0]   o_strength,
    output logic               o_last
);

    localparam int AW      = $clog2(NODE_COUNT);
    localparam int TOP_MAX = (NODE_COUNT - 1 > 31) ? 31 : NODE_COUNT - 1;
    localparam logic [NODE_W-1:0] TOP_CLAMP = NODE_W'(TOP_MAX);

    t_state r_state, n_state;

    logic [NODE_W-1:0]     r_init;
    logic [SEQ_W-1:0]      r_hseq;
    logic [NODE_W-1:0]     r_hnode;
    logic [NODE_COUNT-1:0] r_vld;
    logic [AW-1:0]         r_waddr;
    logic [NODE_W-1:0]     r_k;
    logic [NODE_W-1:0]     r_top;

    logic                  r_o_valid;
    logic                  r_o_kind;
    logic [NODE_W-1:0]     r_o_node;
    logic [STR_W-1:0]      r_o_str;
    logic                  r_o_last;

    logic                  w_accept;
    logic                  w_node_ok;
    logic [NODE_W-1:0]     w_top_raw;
    logic [NODE_W-1:0]     w_top;
    logic [AW-1:0]         w_raddr;
    logic [CNT_W-1:0]      w_rdata;
    logic [CNT_W-1:0]      w_cnt;
    logic [CNT_W-1:0]      w_cnt_inc;
    logic                  w_we;
    logic [PROD_W-1:0]     w_prod;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [STR_W-1:0]      w_quot;

    assign busy      = (r_state != S_IDLE);
    assign w_accept  = start && !busy;
    assign w_node_ok = (32'(i_node_id) < NODE_COUNT);

    assign w_top_raw = (r_hnode > r_init) ? r_hnode : r_init;
    assign w_top     = (w_top_raw > TOP_CLAMP) ? TOP_CLAMP : w_top_raw;

    assign w_raddr = (r_state == S_IDLE) ? AW'(i_node_id) : AW'(r_k);

    // unwritten counters read as zero
    always_comb begin
        if (r_state == S_BWR) begin
            w_cnt = r_vld[r_waddr] ? w_rdata : '0;
        end else begin
            w_cnt = r_vld[AW'(r_k)] ? w_rdata : '0;
        end
    end

    assign w_cnt_inc   = (w_cnt == CNT_MAX) ? w_cnt : w_cnt + 1'b1;
    assign w_we        = (r_state == S_BWR);
    assign w_prod      = PROD_W'(w_cnt) * PROD_W'(RATIO_SCALE);
    assign w_div_start = (r_state == S_MUL);

    brrt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NODE_COUNT),
        .AW    (AW)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_waddr),
        .i_wdata (w_cnt_inc),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    brrt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (r_hseq),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_mode == MODE_BEACON) begin
                        n_state = w_node_ok ? S_BWR : S_IDLE;
                    end else begin
                        n_state = (w_top == '0) ? S_IDLE : S_RD;
                    end
                end
            end
            S_BWR:  n_state = S_IDLE;
            S_RD:   n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = (r_k == r_top) ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_init    <= '0;
            r_hseq    <= '0;
            r_hnode   <= '0;
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_init <= i_cfg_wdata;
            end
            if (w_accept && i_mode == MODE_BEACON && w_node_ok) begin
                if (i_seq > r_hseq) begin
                    r_hseq <= i_seq;
                end
                if (i_node_id > r_hnode) begin
                    r_hnode <= i_node_id;
                end
            end
            if (w_we) begin
                r_vld[r_waddr] <= 1'b1;
            end
            if (w_accept && i_mode == MODE_REPORT) begin
                r_o_valid <= 1'b1;
            end
            if (r_state == S_DIV && w_div_done) begin
                r_o_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_waddr <= AW'(i_node_id);
            r_top   <= w_top;
            r_k     <= NODE_W'(1);
        end else if (r_state == S_DIV && w_div_done) begin
            r_k <= r_k + 1'b1;
        end
        if (w_accept && i_mode == MODE_REPORT) begin
            r_o_kind <= KIND_HEADER;
            r_o_node <= w_top;
            r_o_str  <= '0;
            r_o_last <= (w_top == '0);
        end else if (r_state == S_DIV && w_div_done) begin
            r_o_kind <= KIND_RECORD;
            r_o_node <= r_k;
            r_o_str  <= w_quot;
            r_o_last <= (r_k == r_top);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_node_id_res = r_o_node;
    assign o_strength    = r_o_str;
    assign o_last        = r_o_last;

    a_header_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_mode == MODE_REPORT |=> o_valid && o_kind == KIND_HEADER)
        else $error("report transaction without header");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("still busy after last result");

    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("report ended without last result");

    a_record_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_RECORD |-> o_node_id_res != '0)
        else $error("record for node zero");

endmodule
